// ----- src/kmia_pkg.sv -----
package kmia_pkg;

	localparam int IDX_W   = 30;
	localparam int DIV_W   = 11;
	localparam int DIG_W   = 10;
	localparam int DBL_W   = 11;
	localparam int ACT_W   = 3;
	localparam int NAX     = 3;
	localparam int NLANE   = 3;
	localparam int DIV_CAP = 1024;

	// Restoring division: bits retired per stage, and stages per division.
	localparam int DSTEP   = 5;
	localparam int DSTAGES = IDX_W / DSTEP;

	// Pipeline stage numbers (1-based) of the top level.
	localparam int ST_DIG  = 1 + 2 * DSTAGES;
	localparam int NST     = ST_DIG + 3;
	localparam int ST_BAD  = 4;

	localparam logic [ACT_W-1:0] ACT_ADDR = 3'd0;
	localparam logic [ACT_W-1:0] ACT_XFER = 3'd1;
	localparam logic [ACT_W-1:0] ACT_NEG  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DIFF = 3'd3;
	localparam logic [ACT_W-1:0] ACT_SUM  = 3'd4;
	localparam logic [ACT_W-1:0] ACT_CONS = 3'd5;

	localparam logic [1:0] REG_N0    = 2'd0;
	localparam logic [1:0] REG_N1    = 2'd1;
	localparam logic [1:0] REG_N2    = 2'd2;
	localparam logic [1:0] REG_SHIFT = 2'd3;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [IDX_W-1:0] index_i;
		logic [IDX_W-1:0] index_j;
		logic [IDX_W-1:0] index_a;
	} kmia_in_t;

	typedef struct packed {
		logic [IDX_W-1:0] result_index;
		logic [DBL_W-1:0] doubled_0;
		logic [DBL_W-1:0] doubled_1;
		logic [DBL_W-1:0] doubled_2;
		logic             status;
	} kmia_out_t;

	// Partial remainder and the shifting dividend/quotient word.
	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic [IDX_W-1:0] word;
	} div_part_t;

	function automatic logic [DIV_W-1:0] eff_div(input logic [DIV_W-1:0] v);
		logic [DIV_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIV_W'(1);
		end else if (v > DIV_W'(DIV_CAP)) begin
			r = DIV_W'(DIV_CAP);
		end
		return r;
	endfunction

	function automatic div_part_t div_step(input div_part_t p, input logic [DIV_W-1:0] d);
		div_part_t        q;
		logic [DIV_W-1:0] t;
		q = p;
		for (int k = 0; k < DSTEP; k++) begin
			t = {q.rem[DIV_W-2:0], q.word[IDX_W-1]};
			q.word = {q.word[IDX_W-2:0], 1'b0};
			if (t >= d) begin
				t = t - d;
				q.word[0] = 1'b1;
			end
			q.rem = t;
		end
		return q;
	endfunction

	// Brings a value below three times n back below n.
	function automatic logic [DIG_W-1:0] mod_fold(input logic [DIV_W:0] t,
			input logic [DIV_W-1:0] n);
		logic [DIV_W:0] u;
		u = t;
		if (u >= {1'b0, n}) begin
			u = u - {1'b0, n};
		end
		if (u >= {1'b0, n}) begin
			u = u - {1'b0, n};
		end
		return u[DIG_W-1:0];
	endfunction

endpackage

// ----- src/kmia_div.sv -----
module kmia_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [kmia_pkg::IDX_W-1:0]   dividend,
	input  logic [kmia_pkg::DIV_W-1:0]   divisor,
	output logic [kmia_pkg::IDX_W-1:0]   quotient,
	output logic [kmia_pkg::DIG_W-1:0]   remainder
);
	import kmia_pkg::*;

	div_part_t part_s [DSTAGES];
	div_part_t start;

	assign start = '{rem: '0, word: dividend};

	// Each stage retires five quotient bits; the user must hold the divisor steady while
	// words are in flight, as the block itself does not enforce this.
	always_ff @(posedge clk) begin
		if (en) begin
			part_s[0] <= div_step(start, divisor);
			for (int k = 1; k < DSTAGES; k++) begin
				part_s[k] <= div_step(part_s[k-1], divisor);
			end
		end
	end

	assign quotient  = part_s[DSTAGES-1].word;
	assign remainder = part_s[DSTAGES-1].rem[DIG_W-1:0];

endmodule

// ----- src/kmesh_index_arithmetic.sv -----
// Channel   Direction  Handshake                Word
// in        in         in_valid / in_ready      kmia_in_t  (action, three flat indices)
// out       out        out_valid / out_ready    kmia_out_t (flat index, doubled address, status)
// config    in         APB psel/penable/pwrite  four registers at byte addresses 0, 4, 8, 12
//
// One word can be accepted every cycle while the output drains. Two chained restoring dividers
// of six stages each (five quotient bits a stage) split a flat index into its three axis digits.
// Reset clears the valid bits of every stage and sets the mesh to one point with no shift.
// When the output word is not taken, the whole pipeline holds, so nothing is lost or repeated.
module kmesh_index_arithmetic (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  kmia_pkg::kmia_in_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output kmia_pkg::kmia_out_t  out_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import kmia_pkg::*;

	// Configuration registers, kept as written; the effective division counts are
	// clamped into one to DIV_CAP on the way out.
	logic [DIV_W-1:0] mesh_n0_q;
	logic [DIV_W-1:0] mesh_n1_q;
	logic [DIV_W-1:0] mesh_n2_q;
	logic [NAX-1:0]   shift_flags_q;
	logic [DIV_W-1:0] neff [NAX];
	logic [2*DIV_W-1:0] n01_q;
	logic [IDX_W:0]     size_q;
	logic               cfg_wr;

	// Pipeline control: every stage moves together whenever the output can drain.
	logic             adv;
	logic             vld_p [NST];
	logic [ACT_W-1:0] act_p [ST_DIG];
	logic             bad_p [ST_DIG-ST_BAD+1];
	logic [IDX_W-1:0] idx_s1 [NLANE];
	logic [IDX_W-1:0] idx_s2 [NLANE];
	logic [IDX_W-1:0] idx_s3 [NLANE];
	logic             bad_new;

	// Divider results per lane (lane 0 is index_i, lane 1 index_j, lane 2 index_a).
	logic [IDX_W-1:0] q1 [NLANE];
	logic [DIG_W-1:0] r1 [NLANE];
	logic [IDX_W-1:0] q2 [NLANE];
	logic [DIG_W-1:0] r2 [NLANE];
	logic [DIG_W-1:0] m2_dly [NLANE][DSTAGES];
	logic [DIG_W-1:0] dg [NLANE][NAX];

	// Digit stage, then the two recombination stages.
	logic [DIG_W-1:0] rd_c [NAX];
	logic [DBL_W-1:0] dbl_c [NAX];
	logic             status_c;
	logic [DIG_W-1:0] rd_s14 [NAX];
	logic [DBL_W-1:0] dbl_s14 [NAX];
	logic             status_s14;
	logic [2*DIG_W-1:0] part_s15;
	logic [DIG_W-1:0]   r2_s15;
	logic [DBL_W-1:0]   dbl_s15 [NAX];
	logic               status_s15;
	kmia_out_t          out_s16;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mesh_n0_q     <= DIV_W'(1);
			mesh_n1_q     <= DIV_W'(1);
			mesh_n2_q     <= DIV_W'(1);
			shift_flags_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_N0:    mesh_n0_q     <= pwdata[DIV_W-1:0];
				REG_N1:    mesh_n1_q     <= pwdata[DIV_W-1:0];
				REG_N2:    mesh_n2_q     <= pwdata[DIV_W-1:0];
				REG_SHIFT: shift_flags_q <= pwdata[NAX-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_N0:    prdata = {{(32-DIV_W){1'b0}}, mesh_n0_q};
			REG_N1:    prdata = {{(32-DIV_W){1'b0}}, mesh_n1_q};
			REG_N2:    prdata = {{(32-DIV_W){1'b0}}, mesh_n2_q};
			REG_SHIFT: prdata = {{(32-NAX){1'b0}}, shift_flags_q};
			default:   prdata = '0;
		endcase
	end

	assign neff[0] = eff_div(mesh_n0_q);
	assign neff[1] = eff_div(mesh_n1_q);
	assign neff[2] = eff_div(mesh_n2_q);

	// The point count is registered in two steps after a write, first n01_q and then size_q, and is
	// ready before a word accepted with that write reaches the range check in stage four.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n01_q  <= (2*DIV_W)'(1);
			size_q <= (IDX_W+1)'(1);
		end else begin
			n01_q  <= neff[0] * neff[1];
			size_q <= (IDX_W+1)'(n01_q * neff[2]);
		end
	end

	assign adv       = !vld_p[NST-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_p[NST-1];
	assign out_data  = out_s16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NST; k++) begin
				vld_p[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_p[0] <= in_valid;
			for (int k = 1; k < NST; k++) begin
				vld_p[k] <= vld_p[k-1];
			end
		end
	end

	// An index is out of range if it is used by the action and not below the point count.
	assign bad_new = ({1'b0, idx_s3[0]} >= size_q)
		|| (act_p[ST_BAD-2] >= ACT_DIFF && {1'b0, idx_s3[1]} >= size_q)
		|| (act_p[ST_BAD-2] == ACT_CONS && {1'b0, idx_s3[2]} >= size_q);

	always_ff @(posedge clk) begin
		if (adv) begin
			act_p[0]  <= in_data.action;
			idx_s1[0] <= in_data.index_i;
			idx_s1[1] <= in_data.index_j;
			idx_s1[2] <= in_data.index_a;
			for (int k = 1; k < ST_DIG; k++) begin
				act_p[k] <= act_p[k-1];
			end
			idx_s2 <= idx_s1;
			idx_s3 <= idx_s2;
			bad_p[0] <= bad_new;
			for (int k = 1; k < ST_DIG-ST_BAD+1; k++) begin
				bad_p[k] <= bad_p[k-1];
			end
		end
	end

	// First division by the axis-2 count gives the fastest digit; the second, by the
	// axis-1 count, gives the middle digit as remainder and the slowest as quotient.
	for (genvar l = 0; l < NLANE; l++) begin : g_lane
		kmia_div u_div_a (
			.clk       (clk),
			.en        (adv),
			.dividend  (idx_s1[l]),
			.divisor   (neff[2]),
			.quotient  (q1[l]),
			.remainder (r1[l])
		);

		kmia_div u_div_b (
			.clk       (clk),
			.en        (adv),
			.dividend  (q1[l]),
			.divisor   (neff[1]),
			.quotient  (q2[l]),
			.remainder (r2[l])
		);

		always_ff @(posedge clk) begin
			if (adv) begin
				m2_dly[l][0] <= r1[l];
				for (int k = 1; k < DSTAGES; k++) begin
					m2_dly[l][k] <= m2_dly[l][k-1];
				end
			end
		end

		assign dg[l][0] = q2[l][DIG_W-1:0];
		assign dg[l][1] = r2[l];
		assign dg[l][2] = m2_dly[l][DSTAGES-1];
	end

	// Per-axis digit arithmetic; all sums stay below three times the count, so two
	// conditional subtractions finish the reduction.
	always_comb begin
		logic [DIV_W:0]   t;
		logic [DIV_W:0]   mi;
		logic [DIV_W:0]   mj;
		logic [DIV_W:0]   ma;
		logic [DIV_W:0]   nn;
		logic [ACT_W-1:0] act;
		logic             bad;
		act      = act_p[ST_DIG-1];
		bad      = bad_p[ST_DIG-ST_BAD];
		status_c = bad && (act <= ACT_CONS);
		for (int d = 0; d < NAX; d++) begin
			mi = {2'b00, dg[0][d]};
			mj = {2'b00, dg[1][d]};
			ma = {2'b00, dg[2][d]};
			nn = {1'b0, neff[d]};
			t  = '0;
			dbl_c[d] = '0;
			unique case (act)
				ACT_ADDR: dbl_c[d] = {dg[0][d], shift_flags_q[d]};
				ACT_XFER: dbl_c[d] = {dg[0][d], 1'b0};
				ACT_NEG: begin
					if (shift_flags_q[d]) begin
						t = nn - (DIV_W+1)'(1) - mi;
					end else begin
						t = nn - mi;
					end
				end
				ACT_DIFF: t = mj + nn - mi;
				ACT_SUM:  t = mi + mj;
				ACT_CONS: t = mi + mj + nn - ma;
				default:  t = '0;
			endcase
			if (bad) begin
				dbl_c[d] = '0;
				rd_c[d]  = '0;
			end else begin
				rd_c[d] = mod_fold(t, neff[d]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_s14     <= rd_c;
			dbl_s14    <= dbl_c;
			status_s14 <= status_c;

			part_s15   <= (2*DIG_W)'(rd_s14[0] * neff[1]) + (2*DIG_W)'(rd_s14[1]);
			r2_s15     <= rd_s14[2];
			dbl_s15    <= dbl_s14;
			status_s15 <= status_s14;

			out_s16.result_index <= IDX_W'(part_s15 * neff[2]) + IDX_W'(r2_s15);
			out_s16.doubled_0    <= dbl_s15[0];
			out_s16.doubled_1    <= dbl_s15[1];
			out_s16.doubled_2    <= dbl_s15[2];
			out_s16.status       <= status_s15;
		end
	end

`ifndef SYNTHESIS
	// An out-of-range word carries no result at all.
	a_status_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status |-> out_data.result_index == '0
			&& out_data.doubled_0 == '0 && out_data.doubled_1 == '0
			&& out_data.doubled_2 == '0)
		else $error("status set with a non-zero result");

	// A flat result and a doubled address never come out of the same word.
	a_result_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_index != '0 |-> out_data.doubled_0 == '0
			&& out_data.doubled_1 == '0 && out_data.doubled_2 == '0)
		else $error("flat index and doubled address both present");

	// The point count is never zero, so a valid index always exists.
	a_size_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		size_q != '0)
		else $error("point count is zero");
`endif

endmodule
